@@ sv/tlg_pkg.sv @@
`timescale 1ns / 1ps

package tlg_pkg;

	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLUMNS = 256;
	localparam int CELL_TOTAL  = MAX_ROWS * MAX_COLUMNS;

	localparam int ADDR_W    = $clog2(CELL_TOTAL);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLUMNS);
	localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
	localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
	localparam int SIZE_W    = (ROW_CNT_W > COL_CNT_W) ? ROW_CNT_W : COL_CNT_W;
	localparam int IDX_W     = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int KCNT_W    = $clog2(MAX_COLUMNS + 2);
	localparam int PROD_W    = ROW_CNT_W + COL_CNT_W;

	localparam int CFG_W   = 9;
	localparam int COORD_W = 16;
	localparam int STEP_W  = $clog2(COORD_W);

	// neighbor count of up to eight cells
	localparam int NB_W        = 4;
	localparam int BIRTH_COUNT = 3;
	localparam int KEEP_LOW    = 2;
	localparam int KEEP_HIGH   = 3;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ADDR_W:0]   span_t;

	localparam span_t CELL_END = span_t'(CELL_TOTAL);

	typedef enum logic [1:0] {
		MODE_SET,
		MODE_TOGGLE,
		MODE_ADVANCE,
		MODE_READ
	} mode_t;

	typedef enum logic {
		REG_ROW_COUNT,
		REG_COLUMN_COUNT
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_UP,
		PH_MID,
		PH_DN,
		PH_LAST
	} phase_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MODX,
		ST_MODY,
		ST_MUL_UP,
		ST_MUL_MID,
		ST_MUL_DN,
		ST_FETCH,
		ST_USED,
		ST_CLR_REST,
		ST_ADDR,
		ST_ADDR2,
		ST_RD,
		ST_RESP
	} state_t;

	typedef struct packed {
		addr_t rd_addr;
		logic  wr_en;
		logic  wr_next;
		addr_t wr_addr;
		logic  wr_data;
		logic  flip;
	} brd_cmd_t;

endpackage

@@ sv/tlg_mod_unit.sv @@
`timescale 1ns / 1ps

module tlg_mod_unit import tlg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] dividend,
	input  logic [SIZE_W-1:0]  divisor,
	output logic               done,
	output logic [IDX_W-1:0]   result
);

	logic               run_q;
	logic               neg_q;
	logic               done_q;
	logic [COORD_W-1:0] mag_q;
	logic [SIZE_W-1:0]  rem_q;
	logic [SIZE_W-1:0]  div_q;
	logic [IDX_W-1:0]   res_q;
	logic [STEP_W-1:0]  cnt_q;

	logic [COORD_W-1:0] mag_in;
	logic [SIZE_W:0]    trial;
	logic [SIZE_W:0]    diff;
	logic [SIZE_W-1:0]  rem_nx;
	logic [SIZE_W-1:0]  rem_fin;

	assign mag_in = dividend[COORD_W-1] ? (~dividend + COORD_W'(1)) : dividend;

	// one restoring step per cycle, magnitude bits from the top
	always_comb begin
		trial  = {rem_q, mag_q[COORD_W-1]};
		diff   = trial - {1'b0, div_q};
		rem_nx = (trial >= {1'b0, div_q}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
		// true modulo: a negative value with a nonzero remainder folds up
		rem_fin = (neg_q && rem_nx != '0) ? (div_q - rem_nx) : rem_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			neg_q  <= 1'b0;
			done_q <= 1'b0;
			mag_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			res_q  <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			neg_q  <= dividend[COORD_W-1];
			done_q <= 1'b0;
			mag_q  <= mag_in;
			rem_q  <= '0;
			div_q  <= divisor;
			cnt_q  <= '0;
		end else if (run_q) begin
			rem_q <= rem_nx;
			mag_q <= {mag_q[COORD_W-2:0], 1'b0};
			cnt_q <= cnt_q + STEP_W'(1);
			if (cnt_q == STEP_W'(COORD_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
				res_q  <= rem_fin[IDX_W-1:0];
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ sv/tlg_board.sv @@
`timescale 1ns / 1ps

module tlg_board import tlg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  brd_cmd_t cmd,
	output logic     rd_data
);

	logic mem0 [CELL_TOTAL];
	logic mem1 [CELL_TOTAL];
	logic sel_q;
	logic rd0_q;
	logic rd1_q;
	logic we0;
	logic we1;

	// sel_q marks the buffer that holds the current generation
	assign we1 = cmd.wr_en & (sel_q ^ cmd.wr_next);
	assign we0 = cmd.wr_en & ~(sel_q ^ cmd.wr_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (cmd.flip) begin
			sel_q <= ~sel_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			mem0[cmd.wr_addr] <= cmd.wr_data;
		end
		rd0_q <= mem0[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			mem1[cmd.wr_addr] <= cmd.wr_data;
		end
		rd1_q <= mem1[cmd.rd_addr];
	end

	assign rd_data = sel_q ? rd1_q : rd0_q;

endmodule

@@ sv/tlg_seq.sv @@
`timescale 1ns / 1ps

module tlg_seq import tlg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           mode,
	input  logic [COORD_W-1:0]   x_coord,
	input  logic [COORD_W-1:0]   y_coord,
	input  logic                 new_value,
	input  logic [ROW_CNT_W-1:0] rows,
	input  logic [COL_CNT_W-1:0] cols,
	input  logic                 rd_data,
	output brd_cmd_t             cmd,
	output logic                 busy,
	output logic                 done,
	output logic                 cell_value
);

	state_t state_q, state_d;
	phase_t ph_q;
	mode_t  mode_q;

	logic               new_value_q;
	logic [COORD_W-1:0] y_raw_q;
	logic [COL_W-1:0]   xw_q;
	logic [ROW_W-1:0]   yw_q;
	logic [ROW_W-1:0]   ry_q;
	logic [COL_W-1:0]   fc_q;
	logic [KCNT_W-1:0]  kq_q;
	addr_t              base_up_q;
	addr_t              base_mid_q;
	addr_t              base_dn_q;
	addr_t              cell_addr_q;
	span_t              cq_q;
	logic               col_up_q;
	logic               col_mid_q;
	logic [2:0]         win_c_q;
	logic [2:0]         win_r_q;
	logic               done_q;
	logic               cell_value_q;

	logic                 mod_start;
	logic [COORD_W-1:0]   mod_dividend;
	logic [SIZE_W-1:0]    mod_divisor;
	logic                 mod_done;
	logic [IDX_W-1:0]     mod_result;

	logic [ROW_CNT_W-1:0] mul_a;
	logic [PROD_W-1:0]    prod;

	logic [ROW_CNT_W-1:0] rows_m1_w;
	logic [COL_CNT_W-1:0] cols_m1_w;
	logic [ROW_W-1:0]     rows_m1;
	logic [COL_W-1:0]     cols_m1;
	logic [ROW_W-1:0]     ym1;
	logic [ROW_W-1:0]     yp1;
	logic                 last_row;
	logic                 row_end;
	logic [KCNT_W-1:0]    xk;
	logic [2:0]           new_col;
	logic [NB_W-1:0]      live;
	logic                 self_bit;
	logic                 next_cell;
	logic                 resp_val;
	logic                 edits;

	tlg_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.done     (mod_done),
		.result   (mod_result)
	);

	// shared multiplier: row bases, used area and the addressed cell
	assign prod = mul_a * cols;

	always_comb begin
		rows_m1_w = rows - ROW_CNT_W'(1);
		cols_m1_w = cols - COL_CNT_W'(1);
		rows_m1   = rows_m1_w[ROW_W-1:0];
		cols_m1   = cols_m1_w[COL_W-1:0];
		last_row  = (ry_q == rows_m1);
		ym1       = (ry_q == '0) ? rows_m1 : ry_q - ROW_W'(1);
		yp1       = last_row ? '0 : ry_q + ROW_W'(1);
		row_end   = (kq_q == KCNT_W'(cols) + KCNT_W'(1));
		xk        = kq_q - KCNT_W'(2);
	end

	// window: left column is win_c_q, center win_r_q, right the column just read
	always_comb begin
		new_col  = {rd_data, col_mid_q, col_up_q};
		self_bit = win_r_q[1];
		live = NB_W'(win_c_q[0]) + NB_W'(win_c_q[1]) + NB_W'(win_c_q[2])
		     + NB_W'(win_r_q[0]) + NB_W'(win_r_q[2])
		     + NB_W'(new_col[0]) + NB_W'(new_col[1]) + NB_W'(new_col[2]);
		if (self_bit) begin
			next_cell = (live >= NB_W'(KEEP_LOW)) && (live <= NB_W'(KEEP_HIGH));
		end else begin
			next_cell = (live == NB_W'(BIRTH_COUNT));
		end
	end

	always_comb begin
		edits = (mode_q == MODE_SET) || (mode_q == MODE_TOGGLE);
		case (mode_q)
			MODE_SET:    resp_val = new_value_q;
			MODE_TOGGLE: resp_val = ~rd_data;
			default:     resp_val = rd_data;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cq_q == CELL_END) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_MODX;
			end
			ST_MODX: begin
				if (mod_done) state_d = ST_MODY;
			end
			ST_MODY: begin
				if (mod_done) state_d = (mode_q == MODE_ADVANCE) ? ST_MUL_UP : ST_ADDR;
			end
			ST_MUL_UP:  state_d = ST_MUL_MID;
			ST_MUL_MID: state_d = ST_MUL_DN;
			ST_MUL_DN:  state_d = ST_FETCH;
			ST_FETCH: begin
				if (ph_q == PH_LAST && row_end) state_d = last_row ? ST_USED : ST_MUL_UP;
			end
			ST_USED: state_d = ST_CLR_REST;
			ST_CLR_REST: begin
				if (cq_q == CELL_END) state_d = ST_ADDR;
			end
			ST_ADDR:  state_d = ST_ADDR2;
			ST_ADDR2: state_d = ST_RD;
			ST_RD:    state_d = ST_RESP;
			ST_RESP:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.rd_addr  = cell_addr_q;
		mul_a        = '0;
		mod_start    = 1'b0;
		mod_dividend = x_coord;
		mod_divisor  = SIZE_W'(cols);
		busy         = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_en   = (cq_q != CELL_END);
				cmd.wr_next = 1'b0;
				cmd.wr_addr = cq_q[ADDR_W-1:0];
			end
			ST_IDLE: begin
				mod_start = start;
			end
			ST_MODX: begin
				mod_start    = mod_done;
				mod_dividend = y_raw_q;
				mod_divisor  = SIZE_W'(rows);
			end
			ST_MUL_UP:  mul_a = ROW_CNT_W'(ym1);
			ST_MUL_MID: mul_a = ROW_CNT_W'(ry_q);
			ST_MUL_DN:  mul_a = ROW_CNT_W'(yp1);
			ST_FETCH: begin
				case (ph_q)
					PH_UP:   cmd.rd_addr = base_up_q + ADDR_W'(fc_q);
					PH_MID:  cmd.rd_addr = base_mid_q + ADDR_W'(fc_q);
					PH_DN:   cmd.rd_addr = base_dn_q + ADDR_W'(fc_q);
					default: cmd.rd_addr = cell_addr_q;
				endcase
				// the first two column steps of a row only fill the window
				if (ph_q == PH_LAST && kq_q >= KCNT_W'(2)) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_next = 1'b1;
					cmd.wr_addr = base_mid_q + ADDR_W'(xk[COL_W-1:0]);
					cmd.wr_data = next_cell;
				end
			end
			ST_USED: mul_a = rows;
			ST_CLR_REST: begin
				cmd.wr_en   = (cq_q != CELL_END);
				cmd.wr_next = 1'b1;
				cmd.wr_addr = cq_q[ADDR_W-1:0];
				cmd.flip    = (cq_q == CELL_END);
			end
			ST_ADDR: mul_a = ROW_CNT_W'(yw_q);
			ST_RD:   cmd.rd_addr = cell_addr_q;
			ST_RESP: begin
				cmd.wr_en   = edits;
				cmd.wr_next = 1'b0;
				cmd.wr_addr = cell_addr_q;
				cmd.wr_data = resp_val;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ph_q         <= PH_UP;
			mode_q       <= MODE_READ;
			new_value_q  <= 1'b0;
			y_raw_q      <= '0;
			xw_q         <= '0;
			yw_q         <= '0;
			ry_q         <= '0;
			fc_q         <= '0;
			kq_q         <= '0;
			base_up_q    <= '0;
			base_mid_q   <= '0;
			base_dn_q    <= '0;
			cell_addr_q  <= '0;
			cq_q         <= '0;
			col_up_q     <= 1'b0;
			col_mid_q    <= 1'b0;
			win_c_q      <= '0;
			win_r_q      <= '0;
			done_q       <= 1'b0;
			cell_value_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (cq_q != CELL_END) cq_q <= cq_q + span_t'(1);
				end
				ST_IDLE: begin
					if (start) begin
						mode_q      <= mode_t'(mode);
						new_value_q <= new_value;
						y_raw_q     <= y_coord;
					end
				end
				ST_MODX: begin
					if (mod_done) xw_q <= mod_result[COL_W-1:0];
				end
				ST_MODY: begin
					if (mod_done) begin
						yw_q <= mod_result[ROW_W-1:0];
						ry_q <= '0;
					end
				end
				ST_MUL_UP:  base_up_q  <= prod[ADDR_W-1:0];
				ST_MUL_MID: base_mid_q <= prod[ADDR_W-1:0];
				ST_MUL_DN: begin
					base_dn_q <= prod[ADDR_W-1:0];
					fc_q      <= cols_m1;
					kq_q      <= '0;
					ph_q      <= PH_UP;
				end
				ST_FETCH: begin
					case (ph_q)
						PH_UP:  ph_q <= PH_MID;
						PH_MID: begin
							col_up_q <= rd_data;
							ph_q     <= PH_DN;
						end
						PH_DN: begin
							col_mid_q <= rd_data;
							ph_q      <= PH_LAST;
						end
						default: begin
							win_c_q <= win_r_q;
							win_r_q <= new_col;
							ph_q    <= PH_UP;
							if (row_end) begin
								ry_q <= yp1;
							end else begin
								kq_q <= kq_q + KCNT_W'(1);
								fc_q <= (fc_q == cols_m1) ? '0 : fc_q + COL_W'(1);
							end
						end
					endcase
				end
				ST_USED: cq_q <= prod[ADDR_W:0];
				ST_CLR_REST: begin
					if (cq_q != CELL_END) cq_q <= cq_q + span_t'(1);
				end
				ST_ADDR:  base_mid_q  <= prod[ADDR_W-1:0];
				ST_ADDR2: cell_addr_q <= base_mid_q + ADDR_W'(xw_q);
				ST_RESP: begin
					done_q       <= 1'b1;
					cell_value_q <= resp_val;
				end
				default: begin
					cq_q <= cq_q;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign cell_value = cell_value_q;

endmodule

@@ sv/toroidal_life_generation.sv @@
`timescale 1ns / 1ps

// Wrapped Conway board (B3/S23), one bit per cell, up to 256 by 256. A command
// is taken when start is high and busy is low; its word comes back on
// cell_value with done high for exactly one cycle, and cannot be held off.
// After reset the block is busy while it clears the board. Set, toggle and
// read run two modulo reductions of the coordinates in one shared bit-serial
// unit, then a multiply for the row base and a board read. Advance adds a
// sweep with three board reads per column step through one memory read port,
// then clears the unused area of the new buffer. Size registers must be
// written only while idle; the block itself does not enforce it. 0 acts as 1
// and values above the maximum act as the maximum.
module toroidal_life_generation import tlg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      write_enable,
	input  logic                      reg_index,
	input  logic [CFG_W-1:0]          write_data,
	input  logic                      start,
	input  logic [1:0]                mode,
	input  logic signed [COORD_W-1:0] x_coord,
	input  logic signed [COORD_W-1:0] y_coord,
	input  logic                      new_value,
	output logic                      busy,
	output logic                      done,
	output logic                      cell_value
);

	logic [CFG_W-1:0]     row_count_q;
	logic [CFG_W-1:0]     column_count_q;
	logic [ROW_CNT_W-1:0] rows;
	logic [COL_CNT_W-1:0] cols;
	brd_cmd_t             cmd;
	logic                 rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= CFG_W'(256);
			column_count_q <= CFG_W'(256);
		end else if (write_enable) begin
			case (reg_idx_t'(reg_index))
				REG_ROW_COUNT:    row_count_q    <= write_data;
				REG_COLUMN_COUNT: column_count_q <= write_data;
				default:          row_count_q    <= row_count_q;
			endcase
		end
	end

	// clamp the sizes into 1..max
	always_comb begin
		if (row_count_q == '0) begin
			rows = ROW_CNT_W'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows = ROW_CNT_W'(MAX_ROWS);
		end else begin
			rows = ROW_CNT_W'(row_count_q);
		end
		if (column_count_q == '0) begin
			cols = COL_CNT_W'(1);
		end else if (int'(column_count_q) > MAX_COLUMNS) begin
			cols = COL_CNT_W'(MAX_COLUMNS);
		end else begin
			cols = COL_CNT_W'(column_count_q);
		end
	end

	tlg_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.new_value  (new_value),
		.rows       (rows),
		.cols       (cols),
		.rd_data    (rd_data),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.cell_value (cell_value)
	);

	tlg_board u_board (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_data (rd_data)
	);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tlg_pkg::*;

	typedef struct {
		logic  alive;
		mode_t op;
		int    col;
		int    row;
	} cell_expect_t;

	logic                      clk;
	logic                      arst_n;
	logic                      write_enable;
	logic                      reg_index;
	logic [CFG_W-1:0]          write_data;
	logic                      start;
	logic [1:0]                mode;
	logic signed [COORD_W-1:0] x_coord;
	logic signed [COORD_W-1:0] y_coord;
	logic                      new_value;
	logic                      busy;
	logic                      done;
	logic                      cell_value;

	// board mirror: cell (x,y) sits at y*columns + x, as the block stores it
	bit           board_now [CELL_TOTAL];
	bit           board_gen [CELL_TOTAL];
	logic [8:0]   size_rows;
	logic [8:0]   size_cols;
	cell_expect_t pending_cells [$];

	int  error_count   = 0;
	int  items_sent    = 0;
	int  cells_checked = 0;
	int  generations   = 0;
	int  size_changes  = 0;
	bit  no_gaps       = 1'b0;

	toroidal_life_generation DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_enable(write_enable),
		.reg_index   (reg_index),
		.write_data  (write_data),
		.start       (start),
		.mode        (mode),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.new_value   (new_value),
		.busy        (busy),
		.done        (done),
		.cell_value  (cell_value)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int clamp_dim(logic [8:0] v, int limit);
		if (v == 0)
			return 1;
		if (int'(v) > limit)
			return limit;
		return int'(v);
	endfunction

	// true modulo of a signed coordinate
	function automatic int wrap_axis(logic signed [COORD_W-1:0] c, int n);
		int s;
		int r;
		s = c;
		r = s % n;
		if (r < 0)
			r += n;
		return r;
	endfunction

	function automatic void next_generation(int nr, int nc);
		int live;
		int nx;
		int ny;
		int used;
		used = nr * nc;
		for (int y = 0; y < nr; y++) begin
			for (int x = 0; x < nc; x++) begin
				live = 0;
				for (int dy = -1; dy <= 1; dy++) begin
					for (int dx = -1; dx <= 1; dx++) begin
						if (dx != 0 || dy != 0) begin
							nx = (x + nc + dx) % nc;
							ny = (y + nr + dy) % nr;
							live += board_now[ny * nc + nx];
						end
					end
				end
				if (board_now[y * nc + x])
					board_gen[y * nc + x] = (live == KEEP_LOW || live == KEEP_HIGH);
				else
					board_gen[y * nc + x] = (live == BIRTH_COUNT);
			end
		end
		// clear everything outside the area in use
		for (int a = 0; a < CELL_TOTAL; a++)
			board_now[a] = (a < used) ? board_gen[a] : 1'b0;
	endfunction

	function automatic bit apply_command(mode_t op, logic signed [COORD_W-1:0] xc,
			logic signed [COORD_W-1:0] yc, bit val);
		int nr;
		int nc;
		int addr;
		nr = clamp_dim(size_rows, MAX_ROWS);
		nc = clamp_dim(size_cols, MAX_COLUMNS);
		if (op == MODE_ADVANCE)
			next_generation(nr, nc);
		addr = (wrap_axis(yc, nr) * nc + wrap_axis(xc, nc)) % CELL_TOTAL;
		case (op)
			MODE_SET: board_now[addr] = val;
			MODE_TOGGLE: board_now[addr] = ~board_now[addr];
			default: ;
		endcase
		return board_now[addr];
	endfunction

	// wait until every expected word has arrived and the block is free
	task automatic wait_idle();
		do
			@(negedge clk);
		while (busy || pending_cells.size() != 0);
	endtask

	task automatic set_board_size(logic [8:0] nr, logic [8:0] nc);
		@(negedge clk);
		write_enable <= 1'b1;
		reg_index    <= REG_ROW_COUNT;
		write_data   <= nr;
		@(negedge clk);
		reg_index    <= REG_COLUMN_COUNT;
		write_data   <= nc;
		@(negedge clk);
		write_enable <= 1'b0;
		size_rows = nr;
		size_cols = nc;
		size_changes++;
	endtask

	task automatic send_cmd(mode_t op, logic signed [COORD_W-1:0] xc,
			logic signed [COORD_W-1:0] yc, bit val);
		int           gap;
		cell_expect_t want;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		// leave the block idle for the drawn number of cycles
		if (gap > 0) begin
			do
				@(posedge clk);
			while (busy);
			repeat (gap) @(posedge clk);
		end
		@(negedge clk);
		start     <= 1'b1;
		mode      <= op;
		x_coord   <= xc;
		y_coord   <= yc;
		new_value <= val;
		do
			@(posedge clk);
		while (busy);
		want.alive = apply_command(op, xc, yc, val);
		want.op    = op;
		want.col   = xc;
		want.row   = yc;
		pending_cells.push_back(want);
		items_sent++;
		if (op == MODE_ADVANCE)
			generations++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	always @(posedge clk) begin : check_word
		cell_expect_t want;
		if (arst_n && done) begin
			cells_checked++;
			if (pending_cells.size() == 0) begin
				$error("unexpected word: cell_value=%0b", cell_value);
				error_count++;
			end else begin
				want = pending_cells.pop_front();
				if (cell_value !== want.alive) begin
					$error("cell_value mismatch, %s at (%0d,%0d): expected %0b, actual %0b",
						want.op.name(), want.col, want.row, want.alive, cell_value);
					error_count++;
				end
			end
		end
	end

	task automatic test_cleared_board();
		send_cmd(MODE_READ, 16'sd0, 16'sd0, 1'b1);
		send_cmd(MODE_READ, -16'sd32768, -16'sd32768, 1'b0);
		send_cmd(MODE_READ, 16'sd32767, 16'sd32767, 1'b1);
	endtask

	task automatic test_cell_edits();
		send_cmd(MODE_SET, 16'sd32767, -16'sd32768, 1'b1);
		send_cmd(MODE_READ, -16'sd1, 16'sd0, 1'b0);
		send_cmd(MODE_TOGGLE, -16'sd1, 16'sd256, 1'b1);
		send_cmd(MODE_TOGGLE, 16'sd255, -16'sd256, 1'b0);
		send_cmd(MODE_SET, 16'sd3, 16'sd3, 1'b1);
		send_cmd(MODE_SET, 16'sd3, 16'sd3, 1'b0);
	endtask

	// glider straddling the wrapped corner of the full board
	task automatic test_full_generation();
		send_cmd(MODE_SET, 16'sd0, -16'sd1, 1'b1);
		send_cmd(MODE_SET, 16'sd1, 16'sd0, 1'b1);
		send_cmd(MODE_SET, -16'sd1, 16'sd1, 1'b1);
		send_cmd(MODE_SET, 16'sd0, 16'sd1, 1'b1);
		send_cmd(MODE_SET, 16'sd1, 16'sd1, 1'b1);
		send_cmd(MODE_ADVANCE, -16'sd1, 16'sd0, 1'b0);
	endtask

	task automatic test_size_clamping();
		// zero sizes act as a single cell that neighbors itself eight times
		wait_idle();
		set_board_size(9'd0, 9'd0);
		send_cmd(MODE_SET, 16'sd5, -16'sd7, 1'b1);
		send_cmd(MODE_ADVANCE, 16'sd0, 16'sd0, 1'b1);
		wait_idle();
		set_board_size(9'd3, 9'd3);
		send_cmd(MODE_SET, 16'sd0, 16'sd1, 1'b1);
		send_cmd(MODE_SET, 16'sd1, 16'sd1, 1'b1);
		send_cmd(MODE_SET, -16'sd1, 16'sd4, 1'b1);
		send_cmd(MODE_ADVANCE, 16'sd1, 16'sd0, 1'b0);
		// oversized rows act as the maximum; stored cells are seen through the new shape
		wait_idle();
		set_board_size(9'd511, 9'd2);
		send_cmd(MODE_READ, -16'sd1, -16'sd1, 1'b0);
		send_cmd(MODE_READ, 16'sd1, 16'sd2, 1'b1);
	endtask

	function automatic logic [8:0] pick_dim();
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 4))
				0: return 9'd0;
				1: return 9'd1;
				2: return 9'd256;
				3: return 9'd257;
				default: return 9'd511;
			endcase
		end
		return 9'($urandom_range(2, 10));
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord(int n);
		if ($urandom_range(0, 3) == 0)
			return COORD_W'($urandom_range(0, 65535));
		return COORD_W'(int'($urandom_range(0, 4 * n)) - 2 * n);
	endfunction

	// seed mostly small boards with random cells and run generations over the smaller ones
	task automatic test_random_boards();
		int         taken;
		int         phase_len;
		int         gens_left;
		int         nr;
		int         nc;
		int         pick;
		logic [8:0] raw_rows;
		logic [8:0] raw_cols;
		mode_t      op;
		taken     = 0;
		gens_left = 6;
		while (taken < 80) begin
			raw_rows = pick_dim();
			raw_cols = pick_dim();
			nr = clamp_dim(raw_rows, MAX_ROWS);
			nc = clamp_dim(raw_cols, MAX_COLUMNS);
			wait_idle();
			set_board_size(raw_rows, raw_cols);
			no_gaps   = ($urandom_range(0, 2) == 0);
			phase_len = $urandom_range(10, 16);
			for (int i = 0; i < phase_len; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12 && i >= 6 && gens_left > 0 && nr * nc <= 4096) begin
					op = MODE_ADVANCE;
					gens_left--;
				end else if (pick < 55)
					op = MODE_SET;
				else if (pick < 75)
					op = MODE_TOGGLE;
				else
					op = MODE_READ;
				send_cmd(op, pick_coord(nc), pick_coord(nr), 1'($urandom_range(0, 1)));
				taken++;
				if ($urandom_range(0, 19) == 0)
					wait_idle();
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n       <= 1'b0;
		write_enable <= 1'b0;
		reg_index    <= REG_ROW_COUNT;
		write_data   <= '0;
		start        <= 1'b0;
		mode         <= MODE_READ;
		x_coord      <= '0;
		y_coord      <= '0;
		new_value    <= 1'b0;
		size_rows = 9'd256;
		size_cols = 9'd256;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// hold off until the post-reset clear finishes
		wait_idle();

		test_cleared_board();
		test_cell_edits();
		test_full_generation();
		test_size_clamping();
		test_random_boards();

		wait_idle();
		repeat (100) @(negedge clk);
		if (pending_cells.size() != 0) begin
			$error("%0d words never arrived", pending_cells.size());
			error_count++;
		end
		$display("Sent %0d commands over %0d board sizes, %0d of them generation steps.",
			items_sent, size_changes, generations);
		$display("Compared %0d returned cells against the board mirror.", cells_checked);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("timeout with %0d words outstanding", pending_cells.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
